// File: rtl/morton_leaf_reduction_top_macros.svh
// Assertion macros for the Morton leaf reduction block.
`ifndef MORTON_LEAF_REDUCTION_TOP_MACROS_SVH
`define MORTON_LEAF_REDUCTION_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define MLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define MLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define MLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/mlr_pkg.sv
// Shared constants and controller command types of the Morton leaf reduction block.
package mlr_pkg;

	localparam int DEF_MAX_CODES = 1024;
	localparam int DEF_CODE_BITS = 32;

	// Fixed field widths of the stream items.
	localparam int CODE_W  = 32;
	localparam int FIELD_W = 11;
	localparam int LEVEL_W = 4;
	localparam int OUT_DATA_W = 24;

	// Input item kinds carried in tuser.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// Operation the controller asks of the datapath in a cycle.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_PASS,
		OP_FLUSH,
		OP_COMP,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t  op;
		logic src_b;
		logic busy;
	} cmd_t;

endpackage

// File: rtl/mlr_ctl.sv
// Sequencer for the reduction passes and the final compaction sweep.
module mlr_ctl #(
	parameter int MAX_CODES = mlr_pkg::DEF_MAX_CODES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [mlr_pkg::LEVEL_W-1:0]      level,
	input  logic [$clog2(MAX_CODES+1)-1:0]   code_total,
	output mlr_pkg::cmd_t                    cmd,
	output logic [$clog2(MAX_CODES)-1:0]     addr
);
	import mlr_pkg::*;

	localparam int AW = $clog2(MAX_CODES);
	localparam int CW = $clog2(MAX_CODES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PASS,
		S_PDRAIN,
		S_FLUSH,
		S_COMP,
		S_CDRAIN,
		S_FINISH
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      addr_q;
	logic [LEVEL_W-1:0] pass_q;
	logic [LEVEL_W-1:0] level_q;
	logic               at_last;

	assign at_last = (addr_q == AW'(code_total - CW'(1)));
	assign addr    = addr_q;

	// State, sweep address and pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			addr_q  <= '0;
			pass_q  <= '0;
			level_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						level_q <= level;
						pass_q  <= '0;
						addr_q  <= '0;
						state_q <= (level != '0) ? S_PASS : S_COMP;
					end
				end
				S_PASS: begin
					addr_q <= addr_q + AW'(1);
					if (at_last) begin
						state_q <= S_PDRAIN;
					end
				end
				S_PDRAIN: begin
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					pass_q <= pass_q + LEVEL_W'(1);
					addr_q <= '0;
					state_q <= ((pass_q + LEVEL_W'(1)) == level_q) ? S_COMP : S_PASS;
				end
				S_COMP: begin
					addr_q <= addr_q + AW'(1);
					if (at_last) begin
						state_q <= S_CDRAIN;
					end
				end
				S_CDRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command decode; even passes read table A, the final table follows the level parity.
	always_comb begin
		cmd.busy  = (state_q != S_IDLE);
		cmd.src_b = (state_q == S_COMP) ? level_q[0] : pass_q[0];
		case (state_q)
			S_PASS:   cmd.op = OP_PASS;
			S_FLUSH:  cmd.op = OP_FLUSH;
			S_COMP:   cmd.op = OP_COMP;
			S_FINISH: cmd.op = OP_FINISH;
			default:  cmd.op = OP_NOP;
		endcase
	end

endmodule

// File: rtl/mlr_dp.sv
// Code store, keep tables, leaf list and result logic of the Morton leaf reduction.
module mlr_dp #(
	parameter int MAX_CODES = mlr_pkg::DEF_MAX_CODES,
	parameter int CODE_BITS = mlr_pkg::DEF_CODE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mlr_pkg::cmd_t                    cmd,
	input  logic [$clog2(MAX_CODES)-1:0]     addr,
	input  logic                             load_en,
	input  logic                             read_en,
	input  logic [mlr_pkg::CODE_W-1:0]       code_in,
	input  logic                             out_pop,
	output logic [$clog2(MAX_CODES+1)-1:0]   code_total,
	output logic [$clog2(MAX_CODES+1)-1:0]   kept_total,
	output logic                             out_valid,
	output logic [mlr_pkg::FIELD_W-1:0]      out_index,
	output logic [mlr_pkg::FIELD_W-1:0]      out_leaf_count,
	output logic                             out_done,
	output logic                             out_overflow
);
	import mlr_pkg::*;

	localparam int AW = $clog2(MAX_CODES);
	localparam int CW = $clog2(MAX_CODES + 1);
	localparam int CB = CODE_BITS;
	// Prefix lengths are kept plus one, so zero stands for a missing neighbor.
	localparam int LW = $clog2(CODE_BITS + 2);

	// Leading zeros of the XOR of two codes, plus one.
	function automatic logic [LW-1:0] lz1(input logic [CB-1:0] a, input logic [CB-1:0] b);
		logic [CB-1:0] x;
		logic [LW-1:0] n;
		x = a ^ b;
		n = LW'(CB);
		for (int i = 0; i < CB; i++) begin
			if (x[i]) begin
				n = LW'(CB - 1 - i);
			end
		end
		return n + LW'(1);
	endfunction

	// Memories.
	logic [CB-1:0] code_mem [MAX_CODES];
	logic          fa_mem   [MAX_CODES];
	logic          fb_mem   [MAX_CODES];
	logic [AW-1:0] list_mem [MAX_CODES];

	// Control and count registers.
	logic          res_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] kept_q;
	logic [CW-1:0] rp_q;
	logic [CW-1:0] kc_q;
	logic          ovf_q;
	logic          out_v_q;
	logic          term_q;
	logic [AW-1:0] list_rd_q;
	logic [CB-1:0] prev_load_q;

	// Read stage of the sweeps.
	op_t           op_s1;
	logic [AW-1:0] idx_s1;
	logic          src_b_s1;
	logic [CB-1:0] code_s1;
	logic          fa_s1;
	logic          fb_s1;

	// Scan state of a reduction pass.
	logic          pend_v_q;
	logic [AW-1:0] pend_idx_q;
	logic [CB-1:0] pend_code_q;
	logic [LW-1:0] pend_dm_q;
	logic [LW-1:0] pend_dmm_q;
	logic          pm1_v_q;
	logic [CB-1:0] pm1_code_q;
	logic [CB-1:0] prev_code_q;

	logic [CW-1:0] eff_total;
	logic          store_en;
	logic [CB-1:0] code_m;
	logic          dup_flag;
	logic          rd_sweep;
	logic          first;
	logic          f_s1;
	logic          pend_v;
	logic          pm1_v;
	logic [LW-1:0] d0;
	logic [LW-1:0] dm;
	logic [LW-1:0] dmm;
	logic          dec;
	logic          fw_en;
	logic [AW-1:0] fw_addr;
	logic          fw_data;
	logic          fw_sel_b;
	logic          a_we;
	logic [AW-1:0] a_waddr;
	logic          a_wdata;
	logic          b_we;
	logic [CW-1:0] kc_eff;

	// Load path: a load after results starts a new set.
	assign eff_total = res_q ? '0 : total_q;
	assign store_en  = load_en && (eff_total < CW'(MAX_CODES));
	assign code_m    = CB'(code_in);
	assign dup_flag  = (eff_total == '0) || (code_m != prev_load_q);
	assign rd_sweep  = (cmd.op == OP_PASS) || (cmd.op == OP_COMP);

	// Pass evaluation on the registered read of entry idx_s1.
	assign first  = (idx_s1 == '0);
	assign f_s1   = src_b_s1 ? fb_s1 : fa_s1;
	assign pend_v = pend_v_q && !first;
	assign pm1_v  = pm1_v_q && !first;
	assign d0     = lz1(pend_code_q, code_s1);
	assign dec    = !((d0 < pend_dm_q) && (pend_dmm_q < pend_dm_q));
	assign dm     = first ? '0 : lz1(code_s1, prev_code_q);
	assign dmm    = pm1_v ? lz1(prev_code_q, pm1_code_q) : '0;

	// Keep table write port shared by pass evaluation and the end-of-pass flush.
	always_comb begin
		fw_en    = 1'b0;
		fw_addr  = idx_s1;
		fw_data  = 1'b0;
		fw_sel_b = !src_b_s1;
		if (cmd.op == OP_FLUSH) begin
			fw_en    = pend_v_q;
			fw_addr  = pend_idx_q;
			fw_data  = !(pend_dmm_q < pend_dm_q);
			fw_sel_b = !cmd.src_b;
		end else if (op_s1 == OP_PASS) begin
			if (f_s1) begin
				fw_en   = pend_v;
				fw_addr = pend_idx_q;
				fw_data = dec;
			end else begin
				fw_en   = 1'b1;
				fw_addr = idx_s1;
				fw_data = 1'b0;
			end
		end
	end

	assign a_we    = store_en || (fw_en && !fw_sel_b);
	assign a_waddr = store_en ? eff_total[AW-1:0] : fw_addr;
	assign a_wdata = store_en ? dup_flag : fw_data;
	assign b_we    = fw_en && fw_sel_b;

	assign kc_eff = first ? '0 : kc_q;

	// Code store.
	always_ff @(posedge clk) begin
		if (store_en) begin
			code_mem[eff_total[AW-1:0]] <= code_m;
		end
		if (rd_sweep) begin
			code_s1 <= code_mem[addr];
		end
	end

	// Keep table A.
	always_ff @(posedge clk) begin
		if (a_we) begin
			fa_mem[a_waddr] <= a_wdata;
		end
		if (rd_sweep) begin
			fa_s1 <= fa_mem[addr];
		end
	end

	// Keep table B.
	always_ff @(posedge clk) begin
		if (b_we) begin
			fb_mem[fw_addr] <= fw_data;
		end
		if (rd_sweep) begin
			fb_s1 <= fb_mem[addr];
		end
	end

	// Leaf list filled by compaction, read by result requests.
	always_ff @(posedge clk) begin
		if ((op_s1 == OP_COMP) && f_s1) begin
			list_mem[kc_eff[AW-1:0]] <= idx_s1;
		end
		if (read_en && res_q && (rp_q < kept_q)) begin
			list_rd_q <= list_mem[rp_q[AW-1:0]];
		end
	end

	// Sweep read stage bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NOP;
		end else begin
			op_s1 <= rd_sweep ? cmd.op : OP_NOP;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= addr;
		src_b_s1 <= cmd.src_b;
	end

	// Scan registers of a pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			pm1_v_q  <= 1'b0;
		end else if (op_s1 == OP_PASS) begin
			if (f_s1) begin
				pend_v_q <= 1'b1;
				pm1_v_q  <= !first;
			end else if (first) begin
				pend_v_q <= 1'b0;
				pm1_v_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_s1 == OP_PASS) begin
			prev_code_q <= code_s1;
			if (f_s1) begin
				pend_idx_q  <= idx_s1;
				pend_code_q <= code_s1;
				pend_dm_q   <= dm;
				pend_dmm_q  <= dmm;
				pm1_code_q  <= prev_code_q;
			end
		end
		if (store_en) begin
			prev_load_q <= code_m;
		end
	end

	// Counts, phase and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q   <= 1'b0;
			total_q <= '0;
			kept_q  <= '0;
			rp_q    <= '0;
			kc_q    <= '0;
			ovf_q   <= 1'b0;
			out_v_q <= 1'b0;
			term_q  <= 1'b0;
		end else begin
			if (load_en) begin
				if (res_q) begin
					res_q  <= 1'b0;
					kept_q <= '0;
					rp_q   <= '0;
					ovf_q  <= 1'b0;
				end
				if (store_en) begin
					total_q <= eff_total + CW'(1);
				end else begin
					total_q <= eff_total;
					ovf_q   <= 1'b1;
				end
			end
			if (op_s1 == OP_COMP) begin
				kc_q <= kc_eff + CW'(f_s1);
			end
			if (cmd.op == OP_FINISH) begin
				kept_q <= kc_q;
				rp_q   <= '0;
				res_q  <= 1'b1;
			end
			if (read_en && res_q) begin
				out_v_q <= 1'b1;
				if (rp_q < kept_q) begin
					term_q <= 1'b0;
					rp_q   <= rp_q + CW'(1);
				end else begin
					term_q <= 1'b1;
				end
			end else if (out_pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign code_total     = total_q;
	assign kept_total     = kept_q;
	assign out_valid      = out_v_q;
	assign out_index      = term_q ? FIELD_W'(total_q) : FIELD_W'(list_rd_q);
	assign out_leaf_count = FIELD_W'(kept_q);
	assign out_done       = term_q;
	assign out_overflow   = ovf_q;

endmodule

// File: rtl/morton_leaf_reduction_top.sv
// Loads one code per cycle while idle with a free output register; a read item's result
// is registered and shown in the cycle after it is accepted. After the code marked last
// the block pauses, as each pass (as many as the pass level) and the compaction sweep
// walk the stored codes once through the code store's single read port. Loads and reads
// then go at one per cycle while the output is taken. arst_n clears the phase, counts and
// handshake state at once; the stores are not cleared and need no clearing pass.
module morton_leaf_reduction_top #(
	parameter int MAX_CODES = mlr_pkg::DEF_MAX_CODES,
	parameter int CODE_BITS = mlr_pkg::DEF_CODE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mlr_pkg::LEVEL_W-1:0]       cfg_wdata,    // pass level
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mlr_pkg::CODE_W-1:0]        s_tdata,      // code
	input  logic                              s_tuser,      // mode
	input  logic                              s_tlast,      // last
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mlr_pkg::OUT_DATA_W-1:0]    m_tdata,      // index, leaf_count, zero fill
	output logic                              m_tuser,      // overflow
	output logic                              m_tlast       // done_res
);
	import mlr_pkg::*;

	`include "morton_leaf_reduction_top_macros.svh"

	localparam int AW = $clog2(MAX_CODES);
	localparam int CW = $clog2(MAX_CODES + 1);

	logic [LEVEL_W-1:0] level_q;
	cmd_t               cmd;
	logic [AW-1:0]      addr;
	logic [CW-1:0]      code_total;
	logic [CW-1:0]      kept_total;
	logic               accept;
	logic               start;
	logic [FIELD_W-1:0] out_index;
	logic [FIELD_W-1:0] out_leaf_count;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cfg_we) begin
			level_q <= cfg_wdata;
		end
	end

	// Input handshake: idle controller and a free output register.
	assign s_tready = !cmd.busy && (!m_tvalid || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign start    = accept && (s_tuser == MODE_LOAD) && s_tlast;

	mlr_ctl #(
		.MAX_CODES(MAX_CODES)
	) u_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.level      (level_q),
		.code_total (code_total),
		.cmd        (cmd),
		.addr       (addr)
	);

	mlr_dp #(
		.MAX_CODES(MAX_CODES),
		.CODE_BITS(CODE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.addr           (addr),
		.load_en        (accept && (s_tuser == MODE_LOAD)),
		.read_en        (accept && (s_tuser == MODE_READ)),
		.code_in        (s_tdata),
		.out_pop        (m_tvalid && m_tready),
		.code_total     (code_total),
		.kept_total     (kept_total),
		.out_valid      (m_tvalid),
		.out_index      (out_index),
		.out_leaf_count (out_leaf_count),
		.out_done       (m_tlast),
		.out_overflow   (m_tuser)
	);

	// Pack the result item.
	assign m_tdata = {(OUT_DATA_W - 2 * FIELD_W)'(0), out_leaf_count, out_index};

	// The last code always opens a compute pause.
	`MLR_ASSERT_NXT(a_start_pauses, clk, arst_n, start, !s_tready)
	// No result is pending while the passes run.
	`MLR_ASSERT_IMP(a_busy_no_result, clk, arst_n, cmd.busy, !m_tvalid)
	// A kept index is only returned when some code was kept.
	`MLR_ASSERT_IMP(a_index_needs_leaf, clk, arst_n, m_tvalid && !m_tlast, kept_total != '0)

endmodule
